>>> rtl/core/qyt_pkg.sv
// Shared types, constants and helpers for the quadrature yaw tracker.
`default_nettype none

package qyt_pkg;

    // Default geometry of the encoder disc
    localparam int SLOTS_PER_REV_DEF  = 112;
    localparam int EDGES_PER_SLOT_DEF = 4;

    // Fixed field widths
    localparam int ANG_W = 12;
    localparam int DEG_W = 9;
    localparam int AMT_W = 9;

    // Angle scaling
    localparam int HALF_CIRCLE    = 180;
    localparam int FULL_CIRCLE    = 360;
    localparam int TENTHS_PER_REV = 3600;
    localparam int DEG_PER_REV    = 360;

    // Item opcodes
    typedef enum logic [1:0] {
        OP_SAMPLE = 2'd0,
        OP_INDEX  = 2'd1,
        OP_ADJUST = 2'd2,
        OP_RAMP   = 2'd3
    } t_opcode;

    // Status from the tracker toward the result register
    typedef struct packed {
        logic ramp_zero;   // ramp word found the setpoint already at zero
        logic ref_found;   // index seen, including this word
    } t_trk_sts;

    // Position of an A/B level pair along the Gray sequence 00,01,11,10
    function automatic logic [1:0] gray_rank(input logic [1:0] ab);
        logic [1:0] rank;
        case (ab)
            2'b00:   rank = 2'd0;
            2'b01:   rank = 2'd1;
            2'b11:   rank = 2'd2;
            2'b10:   rank = 2'd3;
            default: rank = 2'd0;
        endcase
        return rank;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/quadrature_yaw_tracker_unit.sv
// Top level of the quadrature yaw tracker: input register, tracker, result register.
//
//  channel  direction  handshake           payload
//  input    in         i_valid / o_stall   i_opcode, i_chan_a, i_chan_b, i_amount
//  result   out        o_valid / i_stall   o_angle_tenths, o_setpoint_deg, o_error_deg,
//                                          o_settled, o_reference_found
//
// One word per cycle unless the result stalls; each word gives exactly one result.
// The result is registered: the word sits in the input register, then tracker update
// and the count scaling multiply feed the result register.
// Synchronous active-low reset clears the count, setpoint, last levels and index flag.
// A stalled result holds; the input register still takes one more word behind it.
`default_nettype none

module quadrature_yaw_tracker_unit #(
    parameter int SLOTS_PER_REV  = qyt_pkg::SLOTS_PER_REV_DEF,
    parameter int EDGES_PER_SLOT = qyt_pkg::EDGES_PER_SLOT_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    output logic                                   o_stall,
    input  wire logic [1:0]                        i_opcode,
    input  wire logic                              i_chan_a,
    input  wire logic                              i_chan_b,
    input  wire logic signed [qyt_pkg::AMT_W-1:0]  i_amount,
    output logic                                   o_valid,
    input  wire logic                              i_stall,
    output logic signed [qyt_pkg::ANG_W-1:0]       o_angle_tenths,
    output logic signed [qyt_pkg::DEG_W-1:0]       o_setpoint_deg,
    output logic signed [qyt_pkg::DEG_W-1:0]       o_error_deg,
    output logic                                   o_settled,
    output logic                                   o_reference_found
);

    localparam int REV   = SLOTS_PER_REV * EDGES_PER_SLOT;
    localparam int CNT_W = $clog2(REV / 2 + 1) + 1;

    // Input register
    logic                             r_in_valid;
    logic [1:0]                       r_in_opcode;
    logic                             r_in_chan_a;
    logic                             r_in_chan_b;
    logic signed [qyt_pkg::AMT_W-1:0] r_in_amount;

    // Result register
    logic                             r_out_valid;
    logic signed [qyt_pkg::ANG_W-1:0] r_out_angle;
    logic signed [qyt_pkg::DEG_W-1:0] r_out_setpoint;
    logic signed [qyt_pkg::DEG_W-1:0] r_out_error;
    logic                             r_out_settled;
    logic                             r_out_ref;

    logic                             adv;
    logic                             in_take;
    logic signed [CNT_W-1:0]          n_count;
    logic signed [qyt_pkg::DEG_W-1:0] n_target;
    logic signed [qyt_pkg::ANG_W-1:0] n_angle;
    logic signed [qyt_pkg::DEG_W-1:0] n_error;
    qyt_pkg::t_trk_sts                trk_sts;

    // Handshake: head word moves on when the result slot is free or draining
    assign adv     = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall = r_in_valid && r_out_valid && i_stall;
    assign in_take = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_opcode <= i_opcode;
            r_in_chan_a <= i_chan_a;
            r_in_chan_b <= i_chan_b;
            r_in_amount <= i_amount;
        end
    end

    qyt_track #(
        .SLOTS_PER_REV  (SLOTS_PER_REV),
        .EDGES_PER_SLOT (EDGES_PER_SLOT)
    ) u_track (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (adv),
        .i_opcode (r_in_opcode),
        .i_chan_a (r_in_chan_a),
        .i_chan_b (r_in_chan_b),
        .i_amount (r_in_amount),
        .o_count  (n_count),
        .o_target (n_target),
        .o_sts    (trk_sts)
    );

    qyt_scale #(
        .SLOTS_PER_REV  (SLOTS_PER_REV),
        .EDGES_PER_SLOT (EDGES_PER_SLOT)
    ) u_scale (
        .i_count        (n_count),
        .i_target       (n_target),
        .o_angle_tenths (n_angle),
        .o_error_deg    (n_error)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_angle    <= n_angle;
            r_out_setpoint <= n_target;
            r_out_error    <= n_error;
            r_out_settled  <= trk_sts.ramp_zero && (n_error == '0);
            r_out_ref      <= trk_sts.ref_found;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_angle_tenths    = r_out_angle;
    assign o_setpoint_deg    = r_out_setpoint;
    assign o_error_deg       = r_out_error;
    assign o_settled         = r_out_settled;
    assign o_reference_found = r_out_ref;

endmodule

`default_nettype wire

>>> rtl/core/qyt_track.sv
// Tracker state: quadrature count, index capture and setpoint update.
`default_nettype none

module qyt_track #(
    parameter int SLOTS_PER_REV  = qyt_pkg::SLOTS_PER_REV_DEF,
    parameter int EDGES_PER_SLOT = qyt_pkg::EDGES_PER_SLOT_DEF
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_adv,
    input  wire logic [1:0]                            i_opcode,
    input  wire logic                                  i_chan_a,
    input  wire logic                                  i_chan_b,
    input  wire logic signed [qyt_pkg::AMT_W-1:0]      i_amount,
    output logic signed [$clog2(SLOTS_PER_REV*EDGES_PER_SLOT/2+1):0] o_count,
    output logic signed [qyt_pkg::DEG_W-1:0]           o_target,
    output qyt_pkg::t_trk_sts                          o_sts
);

    localparam int REV   = SLOTS_PER_REV * EDGES_PER_SLOT;
    localparam int HALF  = REV / 2;
    localparam int CNT_W = $clog2(HALF + 1) + 1;
    localparam int DW    = qyt_pkg::DEG_W;
    localparam int SW    = DW + 1;

    localparam logic signed [CNT_W-1:0] CNT_MAX = CNT_W'(HALF);
    localparam logic signed [CNT_W-1:0] CNT_MIN = CNT_W'(1 - HALF);
    localparam logic signed [SW-1:0]    S_HALF  = SW'(qyt_pkg::HALF_CIRCLE);
    localparam logic signed [SW-1:0]    S_NHALF = SW'(-qyt_pkg::HALF_CIRCLE);
    localparam logic signed [SW-1:0]    S_FULL  = SW'(qyt_pkg::FULL_CIRCLE);

    logic signed [CNT_W-1:0] r_count, n_count;
    logic signed [DW-1:0]    r_target, n_target;
    logic                    r_last_a, n_last_a;
    logic                    r_last_b, n_last_b;
    logic                    r_seen, n_seen;

    qyt_pkg::t_opcode        op;
    logic [1:0]              step;
    logic signed [SW-1:0]    t_ext, a_ext, sum, ramp;

    assign op    = qyt_pkg::t_opcode'(i_opcode);
    assign step  = qyt_pkg::gray_rank({i_chan_a, i_chan_b})
                 - qyt_pkg::gray_rank({r_last_a, r_last_b});
    assign t_ext = SW'(r_target);
    assign a_ext = SW'(i_amount);

    // Next state for the word at the head of the pipe
    always_comb begin
        n_count  = r_count;
        n_target = r_target;
        n_last_a = r_last_a;
        n_last_b = r_last_b;
        n_seen   = r_seen;
        sum      = '0;
        ramp     = t_ext;
        case (op)
            qyt_pkg::OP_SAMPLE: begin
                // one step forward or back, wrapping within one revolution
                if (step == 2'd1) begin
                    n_count = (r_count == CNT_MAX) ? CNT_MIN : r_count + CNT_W'(1);
                end else if (step == 2'd3) begin
                    n_count = (r_count == CNT_MIN) ? CNT_MAX : r_count - CNT_W'(1);
                end
                n_last_a = i_chan_a;
                n_last_b = i_chan_b;
            end
            qyt_pkg::OP_INDEX: begin
                // first index only
                if (!r_seen) begin
                    n_count  = '0;
                    n_target = '0;
                    n_seen   = 1'b1;
                end
            end
            qyt_pkg::OP_ADJUST: begin
                sum = t_ext + a_ext;
                if (sum > S_HALF) begin
                    sum = sum - S_FULL;
                end else if (sum < S_NHALF) begin
                    sum = sum + S_FULL;
                end
                n_target = DW'(sum);
            end
            qyt_pkg::OP_RAMP: begin
                // step toward zero, stop at zero, clamp to half circle
                if (t_ext < 0) begin
                    ramp = t_ext + a_ext;
                    if (ramp > 0) begin
                        ramp = '0;
                    end
                end else if (t_ext > 0) begin
                    ramp = t_ext - a_ext;
                    if (ramp < 0) begin
                        ramp = '0;
                    end
                end
                if (ramp > S_HALF) begin
                    ramp = S_HALF;
                end
                if (ramp < S_NHALF) begin
                    ramp = S_NHALF;
                end
                n_target = DW'(ramp);
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_target <= '0;
            r_last_a <= 1'b0;
            r_last_b <= 1'b0;
            r_seen   <= 1'b0;
        end else if (i_adv) begin
            r_count  <= n_count;
            r_target <= n_target;
            r_last_a <= n_last_a;
            r_last_b <= n_last_b;
            r_seen   <= n_seen;
        end
    end

    assign o_count          = n_count;
    assign o_target         = n_target;
    assign o_sts.ramp_zero  = (op == qyt_pkg::OP_RAMP) && (r_target == '0);
    assign o_sts.ref_found  = n_seen;

endmodule

`default_nettype wire

>>> rtl/core/qyt_scale.sv
// Count to angle scaling and wrapped setpoint error.
`default_nettype none

module qyt_scale #(
    parameter int SLOTS_PER_REV  = qyt_pkg::SLOTS_PER_REV_DEF,
    parameter int EDGES_PER_SLOT = qyt_pkg::EDGES_PER_SLOT_DEF
) (
    input  wire logic signed [$clog2(SLOTS_PER_REV*EDGES_PER_SLOT/2+1):0] i_count,
    input  wire logic signed [qyt_pkg::DEG_W-1:0]  i_target,
    output logic signed [qyt_pkg::ANG_W-1:0]       o_angle_tenths,
    output logic signed [qyt_pkg::DEG_W-1:0]       o_error_deg
);

    localparam int REV   = SLOTS_PER_REV * EDGES_PER_SLOT;
    localparam int HALF  = REV / 2;
    localparam int CNT_W = $clog2(HALF + 1) + 1;
    localparam int MAG_W = CNT_W - 1;
    localparam int AW    = qyt_pkg::ANG_W;
    localparam int DW    = qyt_pkg::DEG_W;
    localparam int EW    = DW + 1;

    // Reciprocal scale: 2^SHIFT above R*R/2 keeps the truncated quotient exact
    localparam int    SHIFT = 2 * $clog2(REV);
    localparam longint K_T  = ((longint'(qyt_pkg::TENTHS_PER_REV) << SHIFT) + REV - 1) / REV;
    localparam longint K_D  = ((longint'(qyt_pkg::DEG_PER_REV) << SHIFT) + REV - 1) / REV;
    localparam int    KT_W  = $clog2(K_T + 1);
    localparam int    KD_W  = $clog2(K_D + 1);
    localparam int    PT_W  = MAG_W + KT_W;
    localparam int    PD_W  = MAG_W + KD_W;

    localparam logic signed [EW-1:0] E_HALF  = EW'(qyt_pkg::HALF_CIRCLE);
    localparam logic signed [EW-1:0] E_NHALF = EW'(-qyt_pkg::HALF_CIRCLE);
    localparam logic signed [EW-1:0] E_FULL  = EW'(qyt_pkg::FULL_CIRCLE);

    logic                 neg;
    logic [MAG_W-1:0]     mag;
    logic [PT_W-1:0]      prod_t;
    logic [PD_W-1:0]      prod_d;
    logic [AW-1:0]        q_t;
    logic [DW-1:0]        q_d;
    logic signed [DW-1:0] deg;
    logic signed [EW-1:0] diff;

    // Magnitude, so both quotients truncate toward zero
    assign neg = i_count[CNT_W-1];
    assign mag = neg ? MAG_W'(-i_count) : MAG_W'(i_count);

    // Tenths and whole degrees, each by one constant multiply
    assign prod_t = PT_W'(mag) * PT_W'(K_T);
    assign prod_d = PD_W'(mag) * PD_W'(K_D);
    assign q_t    = AW'(prod_t >> SHIFT);
    assign q_d    = DW'(prod_d >> SHIFT);

    assign o_angle_tenths = neg ? -$signed(q_t) : $signed(q_t);
    assign deg            = neg ? -$signed(q_d) : $signed(q_d);

    // Setpoint minus angle, wrapped once into the half circle
    always_comb begin
        diff = EW'(i_target) - EW'(deg);
        if (diff > E_HALF) begin
            diff = diff - E_FULL;
        end else if (diff < E_NHALF) begin
            diff = diff + E_FULL;
        end
    end

    assign o_error_deg = DW'(diff);

endmodule

`default_nettype wire

>>> rtl/core/qyt_checker.sv
// Port-level checks for the quadrature yaw tracker, bound to the top level.
`default_nettype none

module qyt_checker (
    input wire logic                              i_clk,
    input wire logic                              i_rst_n,
    input wire logic                              o_stall,
    input wire logic                              o_valid,
    input wire logic                              i_stall,
    input wire logic signed [qyt_pkg::DEG_W-1:0]  o_setpoint_deg,
    input wire logic signed [qyt_pkg::DEG_W-1:0]  o_error_deg,
    input wire logic                              o_settled,
    input wire logic                              o_reference_found
);

    // A stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result dropped while stalled");

    // Input side only backs up behind a held result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled with result slot free");

    // Settled means both setpoint and error are zero
    a_settled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_settled |-> (o_error_deg == '0) && (o_setpoint_deg == '0))
        else $error("settled with nonzero setpoint or error");

    // Reference flag is sticky from one result to the next
    a_ref_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_reference_found |=> o_reference_found)
        else $error("reference flag cleared");

    // Error and setpoint stay within the half circle
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_error_deg <= 9'sd180) && (o_error_deg >= -9'sd180)
                 && (o_setpoint_deg <= 9'sd180) && (o_setpoint_deg >= -9'sd180))
        else $error("angle field out of range");

endmodule

bind quadrature_yaw_tracker_unit qyt_checker u_qyt_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .o_stall           (o_stall),
    .o_valid           (o_valid),
    .i_stall           (i_stall),
    .o_setpoint_deg    (o_setpoint_deg),
    .o_error_deg       (o_error_deg),
    .o_settled         (o_settled),
    .o_reference_found (o_reference_found)
);

`default_nettype wire
